// File: rtl/length_prefixed_record_validator_defines.svh
// Assertion macros for the length-prefixed record validator.
`ifndef LENGTH_PREFIXED_RECORD_VALIDATOR_DEFINES_SVH
`define LENGTH_PREFIXED_RECORD_VALIDATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define LPRV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define LPRV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lprv_pkg.sv
// Shared types and constants for the length-prefixed record validator.
package lprv_pkg;

  localparam logic [7:0] BYTE_NUL = 8'h00;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_CR  = 8'h0D;

  localparam logic [1:0] LAST_FIELD = 2'd2;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_TRUNC  = 3'd1,
    ST_EXTRA  = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_FORBID = 3'd4
  } status_t;

  typedef struct packed {
    logic       byte_valid;
    logic [1:0] field_index;
    logic [7:0] field_byte;
    logic       done_res;
    status_t    status;
  } result_t;

endpackage

// File: rtl/lprv_channels.sv
// Valid/ready channel interfaces for payload words and result words.
interface lprv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface lprv_out_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [1:0] field_index;
  logic [7:0] field_byte;
  logic       done_res;
  logic [2:0] status;

  modport source (output valid, output byte_valid, output field_index, output field_byte,
                  output done_res, output status, input ready);
  modport sink   (input valid, input byte_valid, input field_index, input field_byte,
                  input done_res, input status, output ready);
endinterface

// File: rtl/length_prefixed_record_validator.sv
// The result of an accepted word is registered as the word is taken and is offered in the next cycle.
// Throughput: one word per cycle; the single result register sets the pace,
// and a word is taken whenever that register is empty or being drained.
// Reset (rst, synchronous): parser returns to the first length byte of field 0
// with all error flags clear, and the result register is emptied.
// Top level of the length-prefixed record validator.
module length_prefixed_record_validator import lprv_pkg::*; #(
  parameter int LENGTH_BITS = 16
) (
  input logic        clk,
  input logic        rst,
  lprv_in_if.sink    bytes,
  lprv_out_if.source results
);

`include "length_prefixed_record_validator_defines.svh"

  logic    take;
  result_t res;
  logic    out_valid;
  result_t out_word;

  assign bytes.ready = !out_valid || results.ready;
  assign take        = bytes.valid && bytes.ready;

  lprv_parser #(.LENGTH_BITS(LENGTH_BITS)) u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .in_byte   (bytes.in_byte),
    .last_byte (bytes.last_byte),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (bytes.ready) begin
      out_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_word <= res;
  end

  assign results.valid       = out_valid;
  assign results.byte_valid  = out_word.byte_valid;
  assign results.field_index = out_word.field_index;
  assign results.field_byte  = out_word.field_byte;
  assign results.done_res    = out_word.done_res;
  assign results.status      = out_word.status;

  `LPRV_ASSERT_NEXT(a_take_gives_result, take, results.valid, "accepted word produced no result")
  `LPRV_ASSERT_NOW(a_status_only_done, results.valid && !results.done_res, results.status == ST_OK, "status set without done")
  `LPRV_ASSERT_NOW(a_field_index_range, results.valid && results.byte_valid, results.field_index != 2'd3, "field index out of range")
  `LPRV_ASSERT_NOW(a_idle_byte_zero, results.valid && !results.byte_valid, results.field_byte == 8'd0 && results.field_index == 2'd0, "non-body result carries a byte")

endmodule

// File: rtl/lprv_parser.sv
// Field parser: state update and result for one payload word.
module lprv_parser import lprv_pkg::*; #(
  parameter int LENGTH_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] in_byte,
  input  logic       last_byte,
  output result_t    res
);

  typedef enum logic [1:0] {
    PH_LEN_LO = 2'd0,
    PH_LEN_HI = 2'd1,
    PH_BODY   = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  phase_t                 phase, phase_next;
  logic [1:0]             current_field, current_field_next;
  logic [LENGTH_BITS-1:0] bytes_left, bytes_left_next;
  logic [7:0]             length_low, length_low_next;
  logic                   empty_seen, empty_seen_next;
  logic                   forbidden_seen, forbidden_seen_next;
  logic                   extra_seen, extra_seen_next;

  logic [15:0]            len_word;
  logic [LENGTH_BITS-1:0] len;
  logic [LENGTH_BITS-1:0] left_dec;
  logic                   field_end;

  assign len_word = {in_byte, length_low};
  assign len      = len_word[LENGTH_BITS-1:0];
  assign left_dec = bytes_left - {{(LENGTH_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    phase_next          = phase;
    current_field_next  = current_field;
    bytes_left_next     = bytes_left;
    length_low_next     = length_low;
    empty_seen_next     = empty_seen;
    forbidden_seen_next = forbidden_seen;
    extra_seen_next     = extra_seen;
    field_end           = 1'b0;
    res                 = '0;

    unique case (phase)
      PH_LEN_LO: begin
        length_low_next = in_byte;
        phase_next      = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        if (len == '0) begin
          empty_seen_next = 1'b1;
          field_end       = 1'b1;
        end else begin
          bytes_left_next = len;
          phase_next      = PH_BODY;
        end
      end
      PH_BODY: begin
        res.byte_valid  = 1'b1;
        res.field_index = current_field;
        res.field_byte  = in_byte;
        if (in_byte == BYTE_NUL || in_byte == BYTE_LF || in_byte == BYTE_CR)
          forbidden_seen_next = 1'b1;
        bytes_left_next = left_dec;
        if (left_dec == '0) field_end = 1'b1;
      end
      PH_DONE: begin
        extra_seen_next = 1'b1;
      end
      default: ;
    endcase

    if (field_end) begin
      if (current_field >= LAST_FIELD) begin
        phase_next = PH_DONE;
      end else begin
        current_field_next = current_field + 2'd1;
        phase_next         = PH_LEN_LO;
      end
    end

    if (last_byte) begin
      res.done_res = 1'b1;
      priority if (phase_next != PH_DONE) res.status = ST_TRUNC;
      else if (extra_seen_next)           res.status = ST_EXTRA;
      else if (empty_seen_next)           res.status = ST_EMPTY;
      else if (forbidden_seen_next)       res.status = ST_FORBID;
      else                                res.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_LEN_LO;
      current_field  <= 2'd0;
      empty_seen     <= 1'b0;
      forbidden_seen <= 1'b0;
      extra_seen     <= 1'b0;
    end else if (take) begin
      if (last_byte) begin
        phase          <= PH_LEN_LO;
        current_field  <= 2'd0;
        empty_seen     <= 1'b0;
        forbidden_seen <= 1'b0;
        extra_seen     <= 1'b0;
      end else begin
        phase          <= phase_next;
        current_field  <= current_field_next;
        empty_seen     <= empty_seen_next;
        forbidden_seen <= forbidden_seen_next;
        extra_seen     <= extra_seen_next;
      end
    end
  end

  // Always written before being read, so no reset.
  always_ff @(posedge clk) begin
    if (take) begin
      bytes_left <= bytes_left_next;
      length_low <= length_low_next;
    end
  end

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the length-prefixed record validator.
module testbench import lprv_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEN_BITS    = 16;
  localparam int ITEM_TARGET = 1850;
  localparam int QUIET_TAIL  = 250;
  localparam int HOLD_START  = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 300000;

  typedef enum logic [1:0] {
    EXPECT_LEN_LO,
    EXPECT_LEN_HI,
    IN_BODY,
    FIELDS_DONE
  } parse_phase_t;

  class record_scoreboard;
    parse_phase_t ph;
    logic [1:0]   field;
    logic [15:0]  remaining;
    logic [7:0]   len_low;
    bit           empty_f;
    bit           forbidden_f;
    bit           extra_f;
    result_t      expected_q[$];
    int           mismatches;
    int           accepted;

    function new();
      mismatches = 0;
      accepted   = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      ph          = EXPECT_LEN_LO;
      field       = 2'd0;
      remaining   = 16'd0;
      len_low     = 8'd0;
      empty_f     = 1'b0;
      forbidden_f = 1'b0;
      extra_f     = 1'b0;
    endfunction

    function void advance_field();
      if (field >= LAST_FIELD) begin
        ph = FIELDS_DONE;
      end else begin
        field = field + 2'd1;
        ph    = EXPECT_LEN_LO;
      end
    endfunction

    // Work out the result word for one accepted payload word.
    function void note_input(logic [7:0] b, logic last);
      result_t     r;
      logic [15:0] len;
      logic [15:0] len_mask;
      r        = '0;
      r.status = ST_OK;
      len_mask = 16'((32'h1 << LEN_BITS) - 1);
      case (ph)
        EXPECT_LEN_LO: begin
          len_low = b;
          ph      = EXPECT_LEN_HI;
        end
        EXPECT_LEN_HI: begin
          len = {b, len_low} & len_mask;
          if (len == 16'd0) begin
            empty_f = 1'b1;
            advance_field();
          end else begin
            remaining = len;
            ph        = IN_BODY;
          end
        end
        IN_BODY: begin
          r.byte_valid  = 1'b1;
          r.field_index = field;
          r.field_byte  = b;
          if (b == BYTE_NUL || b == BYTE_LF || b == BYTE_CR) forbidden_f = 1'b1;
          remaining = remaining - 16'd1;
          if (remaining == 16'd0) advance_field();
        end
        default: extra_f = 1'b1;
      endcase
      if (last) begin
        r.done_res = 1'b1;
        if (ph != FIELDS_DONE)  r.status = ST_TRUNC;
        else if (extra_f)       r.status = ST_EXTRA;
        else if (empty_f)       r.status = ST_EMPTY;
        else if (forbidden_f)   r.status = ST_FORBID;
        else                    r.status = ST_OK;
        clear_parse();
      end
      expected_q = {expected_q, r};
      accepted++;
    endfunction

    function void flag(string what, result_t exp, result_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch (%s): exp valid=%0b idx=%0d byte=%02h done=%0b status=%0d",
                 what, exp.byte_valid, exp.field_index, exp.field_byte, exp.done_res,
                 exp.status);
        $display("                  got valid=%0b idx=%0d byte=%02h done=%0b status=%0d",
                 got.byte_valid, got.field_index, got.field_byte, got.done_res, got.status);
      end
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (expected_q.size() == 0) begin
        flag("no word expected", '0, got);
      end else begin
        exp = expected_q.pop_front();
        if (got.byte_valid !== exp.byte_valid || got.field_index !== exp.field_index ||
            got.field_byte !== exp.field_byte || got.done_res !== exp.done_res ||
            got.status !== exp.status) begin
          flag("field", exp, got);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   quiet = 1'b0;
  int   cycle_count = 0;
  record_scoreboard sb = new();

  lprv_in_if  in_ch();
  lprv_out_if out_ch();

  length_prefixed_record_validator #(.LENGTH_BITS(LEN_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .bytes(in_ch),
    .results(out_ch)
  );

  always begin
    #5ns clk = 1'b1;
    #5ns clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("length_prefixed_record_validator regression: fail");
      $finish;
    end
  end

  task automatic send_word(input logic [7:0] b, input logic last);
    in_ch.valid     <= 1'b1;
    in_ch.in_byte   <= b;
    in_ch.last_byte <= last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(b, last);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic send_payload(input logic [7:0] words[$]);
    for (int i = 0; i < words.size(); i++) send_word(words[i], i == words.size() - 1);
  endtask

  // Mostly well-formed records with random bodies; some cut short, some with
  // trailing junk, a few pure noise.
  task automatic send_random_record();
    logic [7:0]  rec[$];
    logic [15:0] len;
    int          kind;
    int          pick;
    int          body_n;
    bit          cut_short;
    kind      = $urandom_range(0, 19);
    cut_short = (kind >= 1 && kind <= 3);
    if (kind == 0) begin
      repeat ($urandom_range(1, 8)) rec = {rec, 8'($urandom_range(0, 255))};
    end else begin
      for (int f = 0; f < 3; f++) begin
        pick = $urandom_range(0, 99);
        if (cut_short && pick < 30)  len = 16'($urandom_range(0, 65535));
        else if (pick < 8)           len = 16'd0;
        else if (pick < 97)          len = 16'($urandom_range(1, 8));
        else                         len = 16'($urandom_range(200, 300));
        rec = {rec, len[7:0]};
        rec = {rec, len[15:8]};
        body_n = (cut_short && len > 16'd12) ? 12 : int'(len);
        for (int i = 0; i < body_n; i++) begin
          pick = $urandom_range(0, 95);
          case (pick)
            0:       rec = {rec, BYTE_NUL};
            1:       rec = {rec, BYTE_LF};
            2:       rec = {rec, BYTE_CR};
            default: rec = {rec, 8'($urandom_range(0, 255))};
          endcase
        end
      end
      if (cut_short) begin
        pick = $urandom_range(1, rec.size() - 1);
        while (rec.size() > pick) void'(rec.pop_back());
      end else if (kind <= 5) begin
        repeat ($urandom_range(1, 3)) rec = {rec, 8'($urandom_range(0, 255))};
      end
    end
    send_payload(rec);
  endtask

  // Result side: random stall bursts, plus one long hold-off that lets the
  // block fill and back-pressure the payload side.
  initial begin
    int      stall_left;
    bit      held;
    result_t got;
    stall_left = 0;
    held       = 1'b0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (out_ch.valid && out_ch.ready) begin
        got.byte_valid  = out_ch.byte_valid;
        got.field_index = out_ch.field_index;
        got.field_byte  = out_ch.field_byte;
        got.done_res    = out_ch.done_res;
        got.status      = status_t'(out_ch.status);
        sb.check_result(got);
      end
      if (!held && sb.accepted >= HOLD_START) begin
        held       = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  initial begin
    logic [7:0] rec[$];
    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.in_byte   <= 8'h00;
    in_ch.last_byte <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // one-byte fields, LF in field 1, last word is also a body word
    rec = '{8'h01, 8'h00, 8'h41, 8'h01, 8'h00, 8'h0A, 8'h01, 8'h00, 8'hFF};
    send_payload(rec);
    // all fields empty plus a trailing word: extra outranks empty
    rec = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0D};
    send_payload(rec);
    // maximum length, cut short after one NUL body word
    rec = '{8'hFF, 8'hFF, 8'h00};
    send_payload(rec);
    // lone word
    rec = '{8'hFF};
    send_payload(rec);

    while (sb.accepted < ITEM_TARGET) begin
      if (sb.accepted >= ITEM_TARGET - QUIET_TAIL) quiet = 1'b1;
      send_random_record();
    end
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("length_prefixed_record_validator regression: pass");
    end else begin
      $display("length_prefixed_record_validator regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/lprv_pkg.sv
rtl/lprv_channels.sv
rtl/lprv_parser.sv
rtl/length_prefixed_record_validator.sv
verif/testbench.sv
